[rtl/srlf_pkg.sv]
// Shared types and constants for the sync/length frame receiver.
package srlf_pkg;

    localparam logic [7:0] FRAME_SYNC = 8'h81;
    localparam int unsigned HDR_BYTES = 2;

    typedef logic [7:0] t_byte;

    // A finished frame handed from the front end to the descriptor queue.
    typedef struct packed {
        logic  push;
        t_byte len;
    } t_push;

    // The oldest waiting frame, as seen by the back end.
    typedef struct packed {
        logic  valid;
        logic  bank;
        t_byte len;
    } t_head;

endpackage

[rtl/sync_length_frame_receiver_unit.sv]
// Top level of the sync/length frame receiver.
//
// Receive side: one serial byte per beat on i_rx_byte, taken when i_rx_valid is
// high and o_rx_stall is low. A frame is the sync byte 0x81, a length byte L and
// then L payload bytes. Bytes that are not sync at the start of a frame are
// dropped, and a length above MAX_PAYLOAD makes the receiver drop the byte that
// follows the full buffer and start over.
// Result side: one payload byte per beat, with o_last on the final byte of the
// frame. A zero-length frame gives a single beat with zero data, o_last and
// o_empty_frame set. A beat moves when o_out_valid is high and i_out_stall low.
// The front end takes one byte per cycle while o_rx_stall is low. Each result of a
// frame goes through reading the memory, loading the output register and handing it
// over (a zero-length frame's beat needs no memory read), and the next read starts
// only once the previous beat has been taken.
// The payload memory has two banks, so a second frame can be received while the
// first drains; with two finished frames waiting, o_rx_stall rises until the
// back end has sent the older one. A stall on the result side only holds the
// output register; the front end keeps taking bytes until both banks are full.
// Reset is synchronous and clears the frame position and the queue, so any
// partial or undelivered frames are discarded. The memory needs no clearing.
module sync_length_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_last,
    output logic       o_empty_frame
);

    localparam int AW = $clog2(2 * MAX_PAYLOAD);

    logic            w_accept;
    logic            w_full;
    logic            w_wr_bank;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    srlf_pkg::t_byte w_wr_data;
    logic [AW-1:0]   w_rd_addr;
    srlf_pkg::t_byte w_rd_data;
    srlf_pkg::t_push w_push;
    srlf_pkg::t_head w_head;
    logic            w_pop;

    // Hold off new bytes only while both memory banks hold finished frames.
    assign o_rx_stall = w_full;
    assign w_accept   = i_rx_valid & ~w_full;

    srlf_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_rx_byte),
        .i_bank   (w_wr_bank),
        .o_wr_en  (w_wr_en),
        .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data),
        .o_push   (w_push)
    );

    srlf_store #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // Queue pointers double as bank selects: the write pointer names the bank
    // being filled, the read pointer the bank being drained.
    srlf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_wr_bank(w_wr_bank),
        .o_head   (w_head)
    );

    srlf_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_payload_byte(o_payload_byte),
        .o_last        (o_last),
        .o_empty_frame (o_empty_frame)
    );

endmodule

[rtl/srlf_front.sv]
// Front end: tracks the frame position, writes payload bytes, reports finished frames.
module srlf_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  srlf_pkg::t_byte                 i_byte,
    input  logic                            i_bank,
    output logic                            o_wr_en,
    output logic [$clog2(2*MAX_PAYLOAD)-1:0] o_wr_addr,
    output srlf_pkg::t_byte                 o_wr_data,
    output srlf_pkg::t_push                 o_push
);

    localparam int DEPTH = MAX_PAYLOAD + 2;
    localparam int PW    = $clog2(MAX_PAYLOAD + 3);
    localparam int AW    = $clog2(2 * MAX_PAYLOAD);

    logic [PW-1:0]   r_pos, n_pos;
    srlf_pkg::t_byte r_len, n_len;
    logic [AW-1:0]   w_idx;
    logic [8:0]      w_end;
    logic [8:0]      w_next;

    assign w_idx  = AW'(r_pos - PW'(srlf_pkg::HDR_BYTES));
    assign w_end  = {1'b0, r_len} + 9'(srlf_pkg::HDR_BYTES);
    assign w_next = 9'(r_pos) + 9'd1;

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        o_wr_en     = 1'b0;
        o_wr_addr   = w_idx + (i_bank ? AW'(MAX_PAYLOAD) : AW'(0));
        o_wr_data   = i_byte;
        o_push.push = 1'b0;
        o_push.len  = r_len;
        if (i_accept) begin
            if (r_pos >= PW'(DEPTH)) begin
                // Store full after an oversized length: drop and restart.
                n_pos = '0;
            end else if (r_pos == PW'(0)) begin
                n_pos = (i_byte == srlf_pkg::FRAME_SYNC) ? PW'(1) : PW'(0);
            end else if (r_pos == PW'(1)) begin
                n_len = i_byte;
                if (i_byte == 8'd0) begin
                    o_push.push = 1'b1;
                    o_push.len  = i_byte;
                    n_pos       = '0;
                end else begin
                    n_pos = PW'(2);
                end
            end else begin
                o_wr_en = 1'b1;
                if (w_next == w_end) begin
                    o_push.push = 1'b1;
                    n_pos       = '0;
                end else begin
                    n_pos = PW'(w_next);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

endmodule

[rtl/srlf_store.sv]
// Two-bank payload memory with one write port and one registered read port.
module srlf_store #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(2*MAX_PAYLOAD)-1:0] i_wr_addr,
    input  srlf_pkg::t_byte                  i_wr_data,
    input  logic [$clog2(2*MAX_PAYLOAD)-1:0] i_rd_addr,
    output srlf_pkg::t_byte                  o_rd_data
);

    srlf_pkg::t_byte r_mem [2*MAX_PAYLOAD];
    srlf_pkg::t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/srlf_queue.sv]
// Two-entry queue of finished frame lengths; its pointers also pick the memory bank.
module srlf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srlf_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_wr_bank,
    output srlf_pkg::t_head o_head
);

    srlf_pkg::t_byte r_len [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push.push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_len[r_wptr] <= i_push.len;
        end
    end

    assign o_full       = (r_count == 2'd2);
    assign o_wr_bank    = r_wptr;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.bank  = r_rptr;
    assign o_head.len   = r_len[r_rptr];

endmodule

[rtl/srlf_back.sv]
// Back end: reads a finished frame's payload and sends it out one beat at a time.
module srlf_back #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  srlf_pkg::t_head                  i_head,
    output logic                             o_pop,
    output logic [$clog2(2*MAX_PAYLOAD)-1:0] o_rd_addr,
    input  srlf_pkg::t_byte                  i_rd_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output srlf_pkg::t_byte                  o_payload_byte,
    output logic                             o_last,
    output logic                             o_empty_frame
);

    localparam int AW = $clog2(2 * MAX_PAYLOAD);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    srlf_pkg::t_byte r_idx, n_idx;
    logic            r_valid, n_valid;
    srlf_pkg::t_byte r_byte, n_byte;
    logic            r_last, n_last;
    logic            r_empty, n_empty;

    assign o_rd_addr = AW'(r_idx) + (i_head.bank ? AW'(MAX_PAYLOAD) : AW'(0));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_empty = r_empty;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_head.valid) begin
                    if (i_head.len == 8'd0) begin
                        n_byte  = '0;
                        n_last  = 1'b1;
                        n_empty = 1'b1;
                        n_valid = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_byte  = i_rd_data;
                n_last  = ((r_idx + 8'd1) == i_head.len);
                n_empty = 1'b0;
                n_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 8'd1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_empty <= n_empty;
    end

    assign o_out_valid    = r_valid;
    assign o_payload_byte = r_byte;
    assign o_last         = r_last;
    assign o_empty_frame  = r_empty;

endmodule

[test/tb_sync_length_frame_receiver_unit.sv]
// Self-checking testbench for the sync/length frame receiver unit.
`timescale 1ns / 100ps

module tb_sync_length_frame_receiver_unit;

    localparam int          MAX_PAYLOAD  = 64;
    localparam int          STORE_DEPTH  = srlf_pkg::HDR_BYTES + MAX_PAYLOAD;
    localparam int          RANDOM_ITEMS = 130;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // One result beat as it leaves the block.
    typedef struct packed {
        srlf_pkg::t_byte data;
        logic            last;
        logic            empty;
    } t_beat;

    // Where the expectation for an accepted byte comes from: none at all, a value typed
    // into the table, or the frame predictor below.
    typedef enum logic [1:0] {
        EXP_NONE,
        EXP_TYPED,
        EXP_MODEL
    } t_exp_kind;

    // One row of the directed table. A row with a count above one sends the bytes
    // rx, rx+1, ... so that a whole payload fits in a single row.
    typedef struct packed {
        srlf_pkg::t_byte rx;
        logic [6:0]      count;
        t_exp_kind       kind;
        t_beat           beat;
    } t_row;

    localparam t_beat NO_BEAT    = '0;
    localparam t_beat EMPTY_BEAT = '{data: 8'h00, last: 1'b1, empty: 1'b1};

    localparam int DIRECTED_COUNT = 30;
    localparam t_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Bytes that are not sync at the start of a frame are dropped.
        '{8'h00, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'hFF, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h80, 7'd1,  EXP_NONE,  NO_BEAT},
        // A zero-length frame gives a single empty beat.
        '{8'h81, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h00, 7'd1,  EXP_TYPED, EMPTY_BEAT},
        // One-byte frames with the payload at both extremes.
        '{8'h81, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h01, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'hFF, 7'd1,  EXP_TYPED, '{data: 8'hFF, last: 1'b1, empty: 1'b0}},
        '{8'h81, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h01, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h00, 7'd1,  EXP_TYPED, '{data: 8'h00, last: 1'b1, empty: 1'b0}},
        // A short frame, then one of the largest length that is still delivered.
        '{8'h81, 7'd1,  EXP_MODEL, NO_BEAT},
        '{8'h03, 7'd1,  EXP_MODEL, NO_BEAT},
        '{8'h7E, 7'd3,  EXP_MODEL, NO_BEAT},
        '{8'h81, 7'd1,  EXP_MODEL, NO_BEAT},
        '{8'h40, 7'd1,  EXP_MODEL, NO_BEAT},
        '{8'hC0, 7'd64, EXP_MODEL, NO_BEAT},
        // Length one above the buffer: the store fills, and the next byte is dropped even
        // though it is a sync byte. The frame after it must come through cleanly.
        '{8'h81, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h41, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h55, 7'd64, EXP_NONE,  NO_BEAT},
        '{8'h81, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h81, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'h00, 7'd1,  EXP_TYPED, EMPTY_BEAT},
        // The largest length byte of all behaves the same way.
        '{8'h81, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'hFF, 7'd1,  EXP_NONE,  NO_BEAT},
        '{8'hAA, 7'd64, EXP_NONE,  NO_BEAT},
        '{8'h00, 7'd1,  EXP_NONE,  NO_BEAT},
        // A payload that carries the sync value itself.
        '{8'h81, 7'd1,  EXP_MODEL, NO_BEAT},
        '{8'h02, 7'd1,  EXP_MODEL, NO_BEAT},
        '{8'h80, 7'd2,  EXP_MODEL, NO_BEAT}
    };

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_rx_valid     = 1'b0;
    logic [7:0] i_rx_byte      = 8'h00;
    logic       i_out_stall    = 1'b0;
    logic       o_rx_stall;
    logic       o_out_valid;
    logic [7:0] o_payload_byte;
    logic       o_last;
    logic       o_empty_frame;

    sync_length_frame_receiver_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_payload_byte(o_payload_byte),
        .o_last        (o_last),
        .o_empty_frame (o_empty_frame)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Frame predictor: its own copy of the write position and the frame store.
    logic [6:0]      frame_pos = '0;
    srlf_pkg::t_byte frame_bytes [STORE_DEPTH];
    t_beat           expected_payload [$];

    // Expectation source for the byte now on the bus. Both are set at the falling edge,
    // together with the byte, and read at the rising edge that takes it.
    t_exp_kind   row_kind = EXP_MODEL;
    t_beat       row_beat = NO_BEAT;

    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;
    bit          hold_request = 1'b0;

    initial begin
        foreach (frame_bytes[n]) frame_bytes[n] = 8'h00;
    end

    // Takes one received byte. When it completes a frame and keep is set, the frame's
    // payload beats are queued as expected results.
    function automatic void deframe_byte(input srlf_pkg::t_byte rx, input bit keep);
        int unsigned len;
        int unsigned k;
        if (frame_pos >= STORE_DEPTH) begin
            // Store already full: this byte is thrown away and the frame restarts.
            frame_pos = '0;
            return;
        end
        frame_bytes[frame_pos] = rx;
        frame_pos++;
        if (frame_bytes[0] != srlf_pkg::FRAME_SYNC) begin
            frame_pos = '0;
            return;
        end
        if (frame_pos < srlf_pkg::HDR_BYTES) return;
        len = frame_bytes[1];
        if (frame_pos < len + srlf_pkg::HDR_BYTES) return;
        frame_pos = '0;
        if (!keep) return;
        if (len == 0) begin
            expected_payload.push_back(EMPTY_BEAT);
        end else begin
            for (k = 0; k < len; k++) begin
                expected_payload.push_back('{data: frame_bytes[srlf_pkg::HDR_BYTES + k],
                                             last: (k + 1 == len), empty: 1'b0});
            end
        end
    endfunction

    // Offers one byte at a falling edge and returns at the falling edge after the beat
    // was taken. The sender works in bursts; between bursts valid may drop for a while.
    task automatic send_rx(input srlf_pkg::t_byte rx);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_rx_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    // Scoreboard. Input beats are predicted first, so an expectation always exists
    // before the matching result beat could be checked.
    always @(posedge i_clk) begin : scoreboard
        t_beat want;
        if (i_rst_n) begin
            if (i_rx_valid && !o_rx_stall) begin
                deframe_byte(i_rx_byte, row_kind == EXP_MODEL);
                if (row_kind == EXP_TYPED) expected_payload.push_back(row_beat);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_payload.size() == 0) begin
                    $error("unexpected result beat: payload_byte %h last %b empty_frame %b",
                           o_payload_byte, o_last, o_empty_frame);
                    fail_count++;
                end else begin
                    want = expected_payload.pop_front();
                    if (o_payload_byte !== want.data) begin
                        $error("payload_byte: expected %h, got %h", want.data, o_payload_byte);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_last);
                        fail_count++;
                    end
                    if (o_empty_frame !== want.empty) begin
                        $error("empty_frame: expected %b, got %b", want.empty, o_empty_frame);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout with %0d result beats outstanding", expected_payload.size());
            $display("** sync_length_frame_receiver_unit: FAILED **");
            $finish;
        end
    end

    // Result side. The stall pattern changes from segment to segment: free flowing,
    // light or heavy random stalls, or a fixed one-in-four pattern. Once, on request,
    // it holds off for a long stretch so that both payload banks fill and the block
    // has to stall its receive side.
    initial begin : result_sink
        int unsigned seg_left;
        int unsigned seg_mode;
        int unsigned phase;
        seg_left = 0;
        seg_mode = 0;
        phase    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 120);
                end
                seg_left--;
                phase++;
                case (seg_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= (phase % 4 == 3);
                endcase
            end
        end
    end

    // Stimulus: reset, the directed table, then random traffic, then drain and verdict.
    initial begin : stimulus
        int unsigned r;
        int unsigned i;
        int unsigned pick;
        int unsigned len;
        int unsigned frame_items;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_COUNT; r++) begin
            for (i = 0; i < DIRECTED_ROWS[r].count; i++) begin
                row_kind = DIRECTED_ROWS[r].kind;
                row_beat = DIRECTED_ROWS[r].beat;
                send_rx(DIRECTED_ROWS[r].rx + srlf_pkg::t_byte'(i));
            end
        end

        // From here on every expectation comes from the predictor.
        row_kind     = EXP_MODEL;
        row_beat     = NO_BEAT;
        frame_items  = 0;
        hold_request = 1'b1;
        while (frame_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Well-formed frame, mostly short, now and then up to the full buffer.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                                  : $urandom_range(0, 8);
                send_rx(srlf_pkg::FRAME_SYNC);
                send_rx(srlf_pkg::t_byte'(len));
                repeat (len) send_rx(srlf_pkg::t_byte'($urandom));
                frame_items += len + srlf_pkg::HDR_BYTES;
            end else if (pick < 82) begin
                // Line noise between frames.
                i = $urandom_range(1, 3);
                repeat (i) send_rx(srlf_pkg::t_byte'($urandom));
                frame_items += i;
            end else if (pick < 94) begin
                // Frame cut short: the bytes that follow are taken as its payload.
                len = $urandom_range(2, 20);
                send_rx(srlf_pkg::FRAME_SYNC);
                send_rx(srlf_pkg::t_byte'(len));
                i = $urandom_range(0, len - 1);
                repeat (i) send_rx(srlf_pkg::t_byte'($urandom));
                frame_items += i + srlf_pkg::HDR_BYTES;
            end else begin
                // Length above the buffer: fill it, then one more byte that gets dropped.
                len = $urandom_range(MAX_PAYLOAD + 1, 255);
                send_rx(srlf_pkg::FRAME_SYNC);
                send_rx(srlf_pkg::t_byte'(len));
                repeat (MAX_PAYLOAD + 1) send_rx(srlf_pkg::t_byte'($urandom));
                frame_items += MAX_PAYLOAD + 1 + srlf_pkg::HDR_BYTES;
            end
        end
        i_rx_valid <= 1'b0;

        while (expected_payload.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_payload.size() == 0) begin
            $display("** sync_length_frame_receiver_unit: PASSED **");
        end else begin
            if (expected_payload.size() != 0)
                $error("%0d expected result beats never arrived", expected_payload.size());
            $display("** sync_length_frame_receiver_unit: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/srlf_pkg.sv
rtl/srlf_front.sv
rtl/srlf_store.sv
rtl/srlf_queue.sv
rtl/srlf_back.sv
rtl/sync_length_frame_receiver_unit.sv
test/tb_sync_length_frame_receiver_unit.sv
